### design/tcte_pkg.sv
// ----------------------------------------------------------------------------
// tcte_pkg
// shared types and constants of the tcp connection table engine
// ----------------------------------------------------------------------------
package tcte_pkg;

    localparam int unsigned ENTRIES_DEF = 4;

    localparam logic [2:0] OP_SEGMENT = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_CONNECT = 3'd2;
    localparam logic [2:0] OP_CLOSE   = 3'd3;
    localparam logic [2:0] OP_ABORT   = 3'd4;

    localparam logic [2:0] ST_CLOSED = 3'd0;
    localparam logic [2:0] ST_OPEN   = 3'd1;
    localparam logic [2:0] ST_OPENED = 3'd2;
    localparam logic [2:0] ST_CLOSE  = 3'd3;
    localparam logic [2:0] ST_ABORT  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_REFUSED = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRIES = 2'd1;
    localparam logic [1:0] REG_APPPORT = 2'd2;

    localparam logic [31:0] INIT_SEQ = 32'd15;
    localparam logic [31:0] INIT_ACK = 32'd1;

    localparam int unsigned IN_W  = 221;
    localparam int unsigned IN_TW = 224;
    localparam int unsigned OUT_W  = 220;
    localparam int unsigned OUT_TW = 224;

    typedef struct packed {
        logic [15:0] rx_window;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [15:0] payload_len;
        logic [7:0]  seg_flags;
        logic [31:0] seg_ack;
        logic [31:0] seg_seq;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [1:0]  entry_sel;
        logic [2:0]  operation;
    } t_in_item;

    typedef struct packed {
        logic [15:0] tx_len;
        logic [47:0] tx_mac;
        logic [31:0] tx_ip;
        logic [15:0] tx_window;
        logic [7:0]  tx_flags;
        logic [31:0] tx_ack;
        logic [31:0] tx_seq;
        logic [15:0] tx_dst_port;
        logic [15:0] tx_src_port;
        logic [1:0]  entry_out;
        logic [1:0]  kind;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] rport;
        logic [15:0] lport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] timer;
        logic [7:0]  errors;
        logic [15:0] window;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    // control between sequencer and entry unit
    typedef struct packed {
        logic        seg;
        logic        tick;
        logic        conn;
        logic [15:0] timeout;
        logic [7:0]  retries;
        logic [15:0] app_port;
    } t_ctl;

    typedef struct packed {
        logic        write;
        logic        send;
        logic [15:0] len;
    } t_res;

endpackage

### design/tcte_unit.sv
// ----------------------------------------------------------------------------
// tcte_unit
// shared per-entry update unit: one entry per cycle through the state rules
// ----------------------------------------------------------------------------
module tcte_unit (
    input  tcte_pkg::t_entry   i_ent,
    input  tcte_pkg::t_in_item i_item,
    input  tcte_pkg::t_ctl     i_ctl,
    input  logic               i_new,
    output tcte_pkg::t_entry   o_ent,
    output tcte_pkg::t_res     o_res
);
    import tcte_pkg::*;

    logic [15:0] tmr;
    logic [7:0]  err;
    logic [31:0] sq_len;
    logic [31:0] sq_one;
    logic [7:0]  fl;

    always_comb begin
        o_ent  = i_ent;
        o_res  = '0;
        fl     = i_item.seg_flags;
        sq_len = i_item.seg_seq + {16'd0, i_item.payload_len};
        sq_one = i_item.seg_seq + 32'd1;
        tmr    = (i_ent.timer != 16'hFFFF) ? i_ent.timer + 16'd1 : i_ent.timer;
        err    = (i_ent.errors != 8'hFF) ? i_ent.errors + 8'd1 : i_ent.errors;
        if (i_ctl.conn) begin
            o_ent.mac = i_item.peer_mac; o_ent.ip = i_item.peer_ip;
            o_ent.rport = i_item.remote_port; o_ent.lport = i_item.local_port;
            o_ent.ack = INIT_ACK; o_ent.seq = INIT_SEQ; o_ent.flags = FL_SYN;
            o_ent.status = ST_OPEN; o_ent.timer = '0; o_ent.errors = '0;
            o_ent.window = i_item.rx_window;
            o_res = '{write: 1'b1, send: 1'b1, len: 16'd0};
        end else if (i_ctl.tick) begin
            if (i_ent.status != ST_CLOSED) begin
                o_ent.timer = tmr;
                o_res.write = 1'b1;
                if (tmr > i_ctl.timeout) begin
                    o_ent.errors = err;
                    o_res.send = 1'b1;
                    if (err > i_ctl.retries) begin
                        o_ent.flags = FL_RST; o_ent.status = ST_CLOSED;
                    end else begin
                        o_ent.timer = i_ctl.timeout;
                    end
                end
            end
        end else if (i_ctl.seg && i_new) begin
            // passive open into a free entry
            o_ent.mac = i_item.peer_mac; o_ent.ip = i_item.peer_ip;
            o_ent.rport = i_item.remote_port; o_ent.lport = i_item.local_port;
            o_ent.ack = sq_one; o_ent.seq = INIT_SEQ; o_ent.flags = FL_SYN | FL_ACK;
            o_ent.timer = '0; o_ent.errors = '0;
            if (fl == FL_SYN) o_ent.status = ST_OPENED;
            else if (fl[0]) o_ent.status = ST_FINISH;
            else o_ent.status = ST_CLOSED;
            o_res = '{write: 1'b1, send: 1'b1, len: 16'd0};
        end else if (i_ctl.seg) begin
            o_ent.timer = '0;
            o_res.write = 1'b1;
            unique case (i_ent.status)
                ST_CLOSE: begin
                    o_ent.ack = sq_len; o_ent.flags = FL_FIN | FL_ACK;
                    o_ent.status = ST_FINISH; o_res.send = 1'b1;
                end
                ST_FINISH: begin
                    if (fl[0] && fl[4]) begin
                        o_ent.seq = i_item.seg_ack; o_ent.ack = sq_one;
                        o_ent.flags = FL_ACK; o_ent.status = ST_CLOSED;
                        o_res.send = 1'b1;
                    end
                end
                ST_OPEN: begin
                    if (fl[0] || fl[2]) begin
                        o_ent.status = ST_CLOSED;
                    end else if (fl[1] && fl[4]) begin
                        o_ent.ack = sq_one; o_ent.seq = i_item.seg_ack;
                        o_ent.flags = FL_ACK; o_ent.status = ST_OPENED;
                        o_res.send = 1'b1; o_res.len = i_item.payload_len;
                    end else begin
                        o_ent.ack = sq_len; o_ent.flags = FL_RST;
                        o_ent.status = ST_CLOSED; o_res.send = 1'b1;
                    end
                end
                ST_OPENED: begin
                    if (fl[2]) begin
                        o_ent.status = ST_CLOSED;
                    end else if (fl[0]) begin
                        o_ent.seq = i_item.seg_ack; o_ent.ack = sq_one;
                        o_ent.flags = FL_FIN | FL_ACK; o_ent.status = ST_FINISH;
                        o_res.send = 1'b1;
                    end else if (i_item.seg_seq != i_ent.ack) begin
                        o_res.send = 1'b1;
                    end else begin
                        o_ent.ack = sq_len; o_ent.flags = FL_ACK;
                        o_res.send = (i_item.remote_port == i_ctl.app_port);
                    end
                end
                ST_ABORT: begin
                    o_ent.ack = sq_len; o_ent.flags = FL_RST;
                    o_ent.status = ST_CLOSED; o_res.send = 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

### design/tcp_connection_table_engine.sv
// ----------------------------------------------------------------------------
// tcp_connection_table_engine
// tcp connection table with a shared per-entry update unit
// ----------------------------------------------------------------------------
// order: a segment or connect searches every entry, takes one update and then,
//   when a header is due, loads the output register; a tick walks one entry a
//   cycle while the output can take a header, and loads its final header last
// throughput: one transaction at a time, the next one accepted only when idle
//   with the output empty, set by the search or walk through the single update unit
// reset: synchronous active low, table closed and zeroed, registers at defaults
module tcp_connection_table_engine #(
    parameter int unsigned ENTRIES = tcte_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // operation, entry_sel, remote_port, local_port, seg_seq, seg_ack,
    // seg_flags, payload_len, peer_ip, peer_mac, rx_window (low bit up)
    input  logic [tcte_pkg::IN_TW-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // kind, entry_out, tx_src_port, tx_dst_port, tx_seq, tx_ack, tx_flags,
    // tx_window, tx_ip, tx_mac, tx_len (low bit up)
    output logic [tcte_pkg::OUT_TW-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [15:0]                i_cfg_data
);
    import tcte_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_UPDATE, S_TICK, S_LAST, S_OUT,
        S_DONE} t_state;

    t_state      r_state;
    t_entry      r_tab [ENTRIES];
    t_in_item    r_item;
    logic [15:0] r_timeout;
    logic [7:0]  r_retries;
    logic [15:0] r_app;
    logic [CW-1:0] r_idx;      // walk counter
    logic [IW-1:0] r_hit;      // entry chosen by the search
    logic        r_found;
    logic        r_free_ok;
    logic [IW-1:0] r_free;
    logic        r_new;
    logic [2:0]  r_cnt;        // headers of this tick so far
    logic        r_last_pend;  // tick header held until the next one or walk end
    t_out_item   r_pend_hdr;
    t_out_item   r_out;
    logic        r_ovalid;
    logic        r_olast;

    t_entry      cur;
    t_entry      upd;
    t_entry      wr_ent;
    t_res        res;
    t_ctl        ctl;
    logic [IW-1:0] widx;
    t_out_item   hdr;
    logic        walk_end;
    logic        out_free;
    logic        out_load;

    assign widx = (r_state == S_TICK) ? r_idx[IW-1:0] : r_hit;
    assign cur  = r_tab[widx];
    assign walk_end = (r_idx == CW'(ENTRIES - 1));

    always_comb begin
        ctl.seg      = (r_item.operation == OP_SEGMENT);
        ctl.tick     = (r_item.operation == OP_TICK);
        ctl.conn     = (r_item.operation == OP_CONNECT);
        ctl.timeout  = r_timeout;
        ctl.retries  = r_retries;
        ctl.app_port = r_app;
    end

    tcte_unit u_unit (.i_ent(cur), .i_item(r_item), .i_ctl(ctl), .i_new(r_new),
        .o_ent(upd), .o_res(res));

    // entry written back: sequence advanced by the payload sent, and by one
    // more for the syn of a passive open
    always_comb begin
        wr_ent     = upd;
        wr_ent.seq = upd.seq + {16'd0, res.len} +
            ((r_new && r_item.seg_flags == FL_SYN && ctl.seg) ? 32'd1 : 32'd0);
    end

    // header formed from the entry before its sequence advances
    always_comb begin
        hdr.kind        = KIND_SEND;
        hdr.entry_out   = 2'(widx);
        hdr.tx_src_port = upd.lport;
        hdr.tx_dst_port = upd.rport;
        hdr.tx_seq      = upd.seq;
        hdr.tx_ack      = upd.flags[4] ? upd.ack : 32'd0;
        hdr.tx_flags    = upd.flags;
        hdr.tx_window   = upd.window;
        hdr.tx_ip       = upd.ip;
        hdr.tx_mac      = upd.mac;
        hdr.tx_len      = res.len;
    end

    // output register loads only when empty or being emptied
    assign out_free = !r_ovalid || m_axis_tready;
    always_comb begin
        out_load = 1'b0;
        unique case (r_state)
            S_UPDATE: out_load = !r_found && !r_free_ok &&
                                 (r_item.operation == OP_CONNECT);
            S_OUT:    out_load = res.send;
            S_TICK:   out_load = out_free && res.send && (r_cnt != 3'd4) &&
                                 r_last_pend;
            S_LAST:   out_load = out_free && r_last_pend;
            default:  out_load = 1'b0;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(OUT_TW - OUT_W)'(0), r_out};
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= 16'd100;
            r_retries <= 8'd5;
            r_app     <= 16'd80;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_last_pend <= 1'b0;
            for (int k = 0; k < ENTRIES; k++) r_tab[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TIMEOUT: r_timeout <= i_cfg_data;
                    REG_RETRIES: r_retries <= i_cfg_data[7:0];
                    REG_APPPORT: r_app     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_item    <= t_in_item'(s_axis_tdata[IN_W-1:0]);
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_cnt     <= '0;
                        r_last_pend <= 1'b0;
                        unique case (s_axis_tdata[2:0])
                            OP_SEGMENT, OP_CONNECT: r_state <= S_SEARCH;
                            OP_TICK: r_state <= S_TICK;
                            OP_CLOSE, OP_ABORT: begin
                                if (32'(s_axis_tdata[4:3]) < ENTRIES)
                                    r_tab[IW'(s_axis_tdata[4:3])].status <=
                                        (s_axis_tdata[2:0] == OP_CLOSE) ?
                                        ST_CLOSE : ST_ABORT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEARCH: begin
                    // one entry a cycle: first port match, first closed entry
                    if (!r_found && r_item.operation == OP_SEGMENT &&
                        r_tab[r_idx[IW-1:0]].lport == r_item.local_port &&
                        r_tab[r_idx[IW-1:0]].rport == r_item.remote_port) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx[IW-1:0];
                    end
                    if (!r_free_ok && r_tab[r_idx[IW-1:0]].status == ST_CLOSED) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_idx[IW-1:0];
                    end
                    r_idx <= r_idx + CW'(1);
                    if (walk_end) r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (r_found) begin
                        r_new <= 1'b0;
                        r_state <= S_OUT;
                    end else if (r_free_ok) begin
                        r_hit <= r_free;
                        r_new <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_item.operation == OP_CONNECT) begin
                        r_out    <= '{kind: KIND_REFUSED, default: '0};
                        r_olast  <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    // single entry update for segment or connect
                    if (res.write) r_tab[widx] <= wr_ent;
                    if (res.send) begin
                        r_out    <= hdr;
                        r_olast  <= 1'b1;
                    end
                    r_state <= res.send ? S_DONE : S_IDLE;
                end
                S_TICK: begin
                    // the held header leaves before a newer one takes its place
                    if (out_free) begin
                        if (res.write) r_tab[widx] <= wr_ent;
                        if (res.send && r_cnt != 3'd4) begin
                            if (r_last_pend) begin
                                r_out   <= r_pend_hdr;
                                r_olast <= 1'b0;
                            end
                            r_pend_hdr  <= hdr;
                            r_last_pend <= 1'b1;
                            r_cnt       <= r_cnt + 3'd1;
                        end
                        r_idx <= r_idx + CW'(1);
                        if (walk_end) r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    // the held header is the final one of the tick
                    if (!r_last_pend) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out       <= r_pend_hdr;
                        r_olast     <= 1'b1;
                        r_last_pend <= 1'b0;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> $stable(r_out)) else $error("output changed");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("too many results");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the tcp connection table engine: random and directed
// segments, ticks, connects, closes and aborts against a behavioral table model
// ----------------------------------------------------------------------------
module testbench;
    import tcte_pkg::*;

    localparam int NENT = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] OP_BAD = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // operation, entry_sel, remote_port, local_port, seg_seq, seg_ack,
    // seg_flags, payload_len, peer_ip, peer_mac, rx_window (low bit up)
    logic [IN_TW-1:0]     s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // kind, entry_out, tx_src_port, tx_dst_port, tx_seq, tx_ack, tx_flags,
    // tx_window, tx_ip, tx_mac, tx_len (low bit up)
    logic [OUT_TW-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_idx;
    logic [15:0]          i_cfg_data;

    tcp_connection_table_engine #(.ENTRIES(NENT)) uut (.*);

    // expected header with its last flag
    typedef struct {
        t_out_item hdr;
        logic      lst;
    } t_expected_hdr;

    // model of the connection table
    t_entry    tbl [NENT];
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_retries;
    logic [15:0] cfg_app_port;

    t_in_item       pending_items [$];
    t_expected_hdr  expected_hdrs [$];
    t_out_item      step_hdrs [$];

    int  errors;
    int  cycles;
    int  hdrs_seen;
    int  items_sent;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_off_cycles;
    bit  stim_done;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // queue one header, dropping any beyond four per transaction
    function automatic void push_hdr(logic [1:0] k, int e, logic [15:0] len);
        t_out_item o;
        o = '0;
        o.kind = k;
        if (k == KIND_SEND) begin
            o.entry_out   = e[1:0];
            o.tx_src_port = tbl[e].lport;
            o.tx_dst_port = tbl[e].rport;
            o.tx_seq      = tbl[e].seq;
            o.tx_ack      = (tbl[e].flags & FL_ACK) != 0 ? tbl[e].ack : 32'd0;
            o.tx_flags    = tbl[e].flags;
            o.tx_window   = tbl[e].window;
            o.tx_ip       = tbl[e].ip;
            o.tx_mac      = tbl[e].mac;
            o.tx_len      = len;
            tbl[e].seq    = tbl[e].seq + 32'(len);
        end
        if (step_hdrs.size() < 4) step_hdrs.push_back(o);
    endfunction

    function automatic int first_closed();
        for (int i = 0; i < NENT; i++)
            if (tbl[i].status == ST_CLOSED) return i;
        return -1;
    endfunction

    function automatic void load_entry(int e, t_in_item it, logic [31:0] ack,
                                       logic [7:0] fl, logic [2:0] st);
        tbl[e].mac    = it.peer_mac;
        tbl[e].ip     = it.peer_ip;
        tbl[e].rport  = it.remote_port;
        tbl[e].lport  = it.local_port;
        tbl[e].ack    = ack;
        tbl[e].seq    = INIT_SEQ;
        tbl[e].flags  = fl;
        tbl[e].status = st;
        tbl[e].timer  = '0;
        tbl[e].errors = '0;
    endfunction

    function automatic void predict_segment(t_in_item it);
        int m;
        int e;
        logic [7:0] fl;
        logic [31:0] sq;
        m = -1;
        fl = it.seg_flags;
        sq = it.seg_seq;
        for (int i = 0; i < NENT; i++)
            if (m < 0 && tbl[i].lport == it.local_port && tbl[i].rport == it.remote_port)
                m = i;
        if (m < 0) begin
            // passive open, window left as stored
            e = first_closed();
            if (e < 0) return;
            if (fl == FL_SYN) begin
                load_entry(e, it, sq + 1, FL_SYN | FL_ACK, ST_OPENED);
                push_hdr(KIND_SEND, e, 0);
                tbl[e].seq = tbl[e].seq + 1;
            end else begin
                load_entry(e, it, sq + 1, FL_SYN | FL_ACK,
                           (fl & FL_FIN) != 0 ? ST_FINISH : ST_CLOSED);
                push_hdr(KIND_SEND, e, 0);
            end
            return;
        end
        e = m;
        tbl[e].timer = '0;
        case (tbl[e].status)
            ST_CLOSE: begin
                tbl[e].ack = sq + 32'(it.payload_len);
                tbl[e].flags = FL_FIN | FL_ACK;
                tbl[e].status = ST_FINISH;
                push_hdr(KIND_SEND, e, 0);
            end
            ST_FINISH: begin
                if ((fl & FL_FIN) != 0 && (fl & FL_ACK) != 0) begin
                    tbl[e].seq = it.seg_ack;
                    tbl[e].ack = sq + 1;
                    tbl[e].flags = FL_ACK;
                    tbl[e].status = ST_CLOSED;
                    push_hdr(KIND_SEND, e, 0);
                end
            end
            ST_OPEN: begin
                if ((fl & (FL_FIN | FL_RST)) != 0) begin
                    tbl[e].status = ST_CLOSED;
                end else if ((fl & FL_SYN) != 0 && (fl & FL_ACK) != 0) begin
                    tbl[e].ack = sq + 1;
                    tbl[e].seq = it.seg_ack;
                    tbl[e].flags = FL_ACK;
                    tbl[e].status = ST_OPENED;
                    push_hdr(KIND_SEND, e, it.payload_len);
                end else begin
                    tbl[e].ack = sq + 32'(it.payload_len);
                    tbl[e].flags = FL_RST;
                    tbl[e].status = ST_CLOSED;
                    push_hdr(KIND_SEND, e, 0);
                end
            end
            ST_OPENED: begin
                if ((fl & FL_RST) != 0) begin
                    tbl[e].status = ST_CLOSED;
                end else if ((fl & FL_FIN) != 0) begin
                    tbl[e].seq = it.seg_ack;
                    tbl[e].ack = sq + 1;
                    tbl[e].flags = FL_FIN | FL_ACK;
                    tbl[e].status = ST_FINISH;
                    push_hdr(KIND_SEND, e, 0);
                end else if (sq != tbl[e].ack) begin
                    // out of order: repeat the current ack
                    push_hdr(KIND_SEND, e, 0);
                end else begin
                    tbl[e].ack = sq + 32'(it.payload_len);
                    tbl[e].flags = FL_ACK;
                    if (it.remote_port == cfg_app_port) push_hdr(KIND_SEND, e, 0);
                end
            end
            ST_ABORT: begin
                tbl[e].ack = sq + 32'(it.payload_len);
                tbl[e].flags = FL_RST;
                tbl[e].status = ST_CLOSED;
                push_hdr(KIND_SEND, e, 0);
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_tick();
        for (int e = 0; e < NENT; e++) begin
            if (tbl[e].status != ST_CLOSED) begin
                if (tbl[e].timer != 16'hFFFF) tbl[e].timer++;
                if (tbl[e].timer > cfg_timeout) begin
                    if (tbl[e].errors != 8'hFF) tbl[e].errors++;
                    if (tbl[e].errors > cfg_retries) begin
                        tbl[e].flags = FL_RST;
                        tbl[e].status = ST_CLOSED;
                    end else begin
                        tbl[e].timer = cfg_timeout;
                    end
                    push_hdr(KIND_SEND, e, 0);
                end
            end
        end
    endfunction

    // work out the headers caused by one accepted transaction
    function automatic void predict_table_step(t_in_item it);
        int e;
        t_expected_hdr x;
        step_hdrs.delete();
        case (it.operation)
            OP_SEGMENT: predict_segment(it);
            OP_TICK:    predict_tick();
            OP_CONNECT: begin
                e = first_closed();
                if (e < 0) begin
                    push_hdr(KIND_REFUSED, 0, 0);
                end else begin
                    load_entry(e, it, INIT_ACK, FL_SYN, ST_OPEN);
                    tbl[e].window = it.rx_window;
                    push_hdr(KIND_SEND, e, 0);
                end
            end
            OP_CLOSE: tbl[it.entry_sel].status = ST_CLOSE;
            OP_ABORT: tbl[it.entry_sel].status = ST_ABORT;
            default: ;
        endcase
        foreach (step_hdrs[i]) begin
            x.hdr = step_hdrs[i];
            x.lst = (i == step_hdrs.size() - 1);
            expected_hdrs.push_back(x);
        end
    endfunction

    // driver: offers queued transactions, idles at the chosen rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_table_step(t_in_item'(s_axis_tdata[IN_W-1:0]));
                items_sent++;
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    s_axis_tdata  <= IN_TW'(pending_items.pop_front());
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with an optional long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // monitor: compares each header transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item got;
        t_expected_hdr x;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_out_item'(m_axis_tdata[OUT_W-1:0]);
            hdrs_seen++;
            if (expected_hdrs.size() == 0) begin
                $display("%0t: unexpected header, expected none, actual %h", $realtime,
                         got);
                errors++;
            end else begin
                x = expected_hdrs.pop_front();
                if (got !== x.hdr || m_axis_tlast !== x.lst) begin
                    $display("%0t: header mismatch, expected %h last %b, actual %h last %b",
                             $realtime, x.hdr, x.lst, got, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_TIMEOUT: cfg_timeout  = val;
            REG_RETRIES: cfg_retries  = val[7:0];
            default:     cfg_app_port = val;
        endcase
    endtask

    // wait until every transaction went in and every header came out,
    // then allow the tick walk to finish
    task automatic drain();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_hdrs.size() > 0)
            @(posedge i_clk);
        repeat (3 * NENT + 12) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic [2:0] op, logic [15:0] rp, logic [15:0] lp,
                                    logic [31:0] sq, logic [31:0] ak, logic [7:0] fl,
                                    logic [15:0] len);
        t_in_item it;
        it.operation   = op;
        it.entry_sel   = 2'($urandom);
        it.remote_port = rp;
        it.local_port  = lp;
        it.seg_seq     = sq;
        it.seg_ack     = ak;
        it.seg_flags   = fl;
        it.payload_len = len;
        it.peer_ip     = $urandom;
        it.peer_mac    = {16'($urandom), 32'($urandom)};
        it.rx_window   = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_ctl(logic [2:0] op, logic [1:0] sel);
        t_in_item it;
        it = mk(op, 16'($urandom), 16'($urandom), $urandom, $urandom, 8'($urandom),
                16'($urandom));
        it.entry_sel = sel;
        return it;
    endfunction

    // a short conversation on a small port pool so that lookups hit entries
    task automatic queue_random(int n);
        logic [15:0] rp, lp;
        logic [7:0]  fl;
        logic [2:0]  op;
        int r;
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            r  = $urandom_range(99);
            rp = $urandom_range(3) == 0 ? cfg_app_port : 16'($urandom_range(1000, 1003));
            lp = 16'($urandom_range(2000, 2002));
            case ($urandom_range(5))
                0: fl = FL_SYN;
                1: fl = FL_SYN | FL_ACK;
                2: fl = FL_ACK;
                3: fl = FL_FIN | FL_ACK;
                4: fl = FL_RST;
                default: fl = 8'($urandom);
            endcase
            if (r < 45) op = OP_SEGMENT;
            else if (r < 65) op = OP_TICK;
            else if (r < 80) op = OP_CONNECT;
            else if (r < 88) op = OP_CLOSE;
            else if (r < 96) op = OP_ABORT;
            else op = 3'($urandom_range(5, 7));
            it = mk(op, rp, lp, $urandom_range(3) == 0 ? 32'($urandom_range(0, 20)) : $urandom,
                    $urandom, fl, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8)));
            if ($urandom_range(9) == 0) begin
                it.remote_port = 16'($urandom);
                it.local_port  = 16'($urandom);
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_TIMEOUT;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        hdrs_seen = 0;
        items_sent = 0;
        hold_off_cycles = 0;
        stim_done = 1'b0;
        sender_idle_pct = 8;
        receiver_idle_pct = 67;
        foreach (tbl[i]) tbl[i] = '0;
        cfg_timeout = 16'd100;
        cfg_retries = 8'd5;
        cfg_app_port = 16'd80;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short timeout so ticks retransmit and expire quickly
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_RETRIES, 8'd0);
        write_reg(REG_APPPORT, 16'hFFFF);
        pending_items.push_back(mk(OP_CONNECT, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_SEGMENT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, FL_SYN | FL_ACK, 16'hFFFF));
        pending_items.push_back(mk(OP_SEGMENT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   0, FL_ACK, 0));
        pending_items.push_back(mk(OP_SEGMENT, 16'hFFFF, 16'hFFFF, 32'd3, 0, FL_ACK, 5));
        pending_items.push_back(mk(OP_SEGMENT, 16'd0, 16'd0, 32'd0, 0, FL_SYN, 0));
        pending_items.push_back(mk(OP_SEGMENT, 16'd1, 16'd1, 32'd7, 0, FL_FIN, 0));
        pending_items.push_back(mk(OP_SEGMENT, 16'd2, 16'd2, 32'd7, 0, 8'hFF, 0));
        pending_items.push_back(mk(OP_CONNECT, 16'd9, 16'd9, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_CONNECT, 16'd10, 16'd10, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_SEGMENT, 16'd11, 16'd11, 0, 0, FL_SYN, 0));
        pending_items.push_back(mk_ctl(OP_CLOSE, 2'd0));
        pending_items.push_back(mk(OP_SEGMENT, 16'hFFFF, 16'hFFFF, 32'd1, 0, 0, 4));
        pending_items.push_back(mk(OP_SEGMENT, 16'hFFFF, 16'hFFFF, 32'd1, 32'd9,
                                   FL_FIN | FL_ACK, 0));
        pending_items.push_back(mk_ctl(OP_ABORT, 2'd3));
        pending_items.push_back(mk_ctl(OP_BAD, 2'd0));
        pending_items.push_back(mk_ctl(3'd5, 2'd1));
        pending_items.push_back(mk(OP_SEGMENT, 16'd9, 16'd9, 0, 0, FL_RST, 0));
        pending_items.push_back(mk_ctl(OP_TICK, 2'd0));
        pending_items.push_back(mk_ctl(OP_TICK, 2'd0));
        pending_items.push_back(mk_ctl(OP_TICK, 2'd0));
        // wipe anything still alive: abort everything then tick it out
        for (int i = 0; i < NENT; i++) pending_items.push_back(mk_ctl(OP_ABORT, 2'(i)));
        pending_items.push_back(mk_ctl(OP_TICK, 2'd0));
        drain();

        // phase one: sender seldom idle, receiver mostly idle, with a stall
        write_reg(REG_TIMEOUT, 16'd3);
        write_reg(REG_RETRIES, 8'd2);
        write_reg(REG_APPPORT, 16'd1001);
        hold_off_cycles = 300;
        queue_random(32);
        drain();

        // phase two: the other way round, large limits
        sender_idle_pct = 67;
        receiver_idle_pct = 8;
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_RETRIES, 8'hFF);
        write_reg(REG_APPPORT, 16'd0);
        queue_random(32);
        drain();

        // phase three: no idling on either side
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_reg(REG_TIMEOUT, 16'd2);
        write_reg(REG_RETRIES, 8'd1);
        write_reg(REG_APPPORT, 16'd80);
        queue_random(32);
        drain();

        $display("covered %0d transactions in, %0d headers out across four settings",
                 items_sent, hdrs_seen);
        $display("segments, ticks, connects, closes, aborts and unknown operations mixed");
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
